// ----- hdl/mfe_pkg.sv -----
// Package of shared types and constants for the max flow engine.
`default_nettype none
package mfe_pkg;
	localparam int unsigned VtxW = 10;
	localparam int unsigned ArcW = 12;
	localparam int unsigned ArcPW = 13;
	localparam int unsigned CapW = 30;
	localparam int unsigned LvlW = 11;
	localparam int unsigned FlowW = 42;
	localparam int unsigned NumVtx = 1024;
	localparam int unsigned NumArc = 4096;
	localparam logic [ArcPW-1:0] ArcNil = 13'd4096;
	localparam logic [LvlW-1:0] LvlNone = 11'h7ff;
	localparam logic [CapW-1:0] PathCap = 30'h3f3f3f3f;

	// Configuration register indexes.
	localparam logic CfgSource = 1'b0;
	localparam logic CfgSink = 1'b1;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FULL   = 2'd1,
		ST_FLOW   = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		K_ADD = 1'b0,
		K_COMPUTE = 1'b1
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ADD_F, S_ADD_RD, S_ADD_R, S_LVL_CLR, S_BFS_SEED, S_BFS_POP,
		S_BFS_V, S_BFS_VW, S_BFS_ARC, S_BFS_ARCW, S_BFS_CHK, S_CHK_T, S_CHK_TW,
		S_CUR_RD, S_CUR_WR, S_DFS_T, S_DFS_CW, S_DFS_AW, S_DFS_LVL, S_POP_RD,
		S_POP_P, S_POP_H, S_AUG_MIN, S_AUG_MP, S_AUG_MR, S_AUG_UPD, S_AUG_UP,
		S_AUG_UF, S_AUG_RR, S_AUG_RF, S_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/mfe_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module mfe_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- hdl/max_flow_engine_unit.sv -----
// Top level of the max flow engine: stream ports, sequencer and state memories.
//
// Usage: input items arrive on s_axis (tdata: kind, from_vertex, to_vertex,
// capacity, from the lowest bit up). Every item gives exactly one result item
// on m_axis (tdata: status, total_flow). One item is processed at a time.
// An add item writes the new arc and its reverse partner through the states
// S_ADD_F, S_ADD_RD and S_ADD_R; its result is then loaded in S_OUT, and the
// block takes the next item once it is back in S_IDLE.
// An add item that finds the arc table full goes straight to S_OUT and is answered.
// A compute item with source and sink apart runs Dinic phases. Each phase
// clears all vertex levels, runs a breadth-first pass over the dequeued
// vertices and the arcs they scan, copies the arc cursors from the first-arc
// table and then searches paths, retreating from dead ends and augmenting
// the flow along each path that reaches the sink. The last phase stops after
// its breadth-first pass.
// Reset clears the arc count and runs a pass that sets every first-arc entry
// to null; no item is accepted during it. Configuration
// writes (source_vertex, sink_vertex) are taken in any cycle.
// The result waits in an output register, so the block can take the next item
// while the receiver stalls; if a second result is ready before the first has
// left, the block holds it and accepts no new item.
`default_nettype none
module max_flow_engine_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// kind[0], from_vertex[10:1], to_vertex[20:11], capacity[50:21]
	input  wire logic [55:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// status[1:0], total_flow[43:2]
	output logic [47:0] m_axis_tdata,
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [9:0] cfg_wdata
);
	import mfe_pkg::*;

	state_t state_q, state_n;
	logic [VtxW-1:0] src_q, snk_q;
	logic [ArcPW-1:0] cnt_q;
	logic [VtxW:0] clr_q;
	logic clr_busy;
	logic tbl_full;
	logic [VtxW-1:0] u_q, w_q, v_q, h_q;
	logic [CapW-1:0] cap_q, b_q, rr_q;
	logic [ArcPW-1:0] a_q, nxt_q;
	logic [LvlW-1:0] lv_q;
	logic [VtxW:0] qh_q, qt_q, dep_q, i_q;
	logic [FlowW-1:0] flow_q;
	status_t st_q;
	logic m_valid_q;
	logic [47:0] m_data_q;
	logic out_load;
	logic bfs_take, dfs_take;
	logic [ArcW-1:0] rev_a, pair_a;

	// memory ports
	logic he, re, ne, fe, le, ce, qe, pe;
	logic [ArcW-1:0] ha, ra, na;
	logic [VtxW-1:0] fa, la, ca, qa, pa;
	logic [VtxW-1:0] hw, hr, qw, qr;
	logic [CapW-1:0] rw, rr;
	logic [ArcPW-1:0] nw, nr, fw, fr, cw, cr, pw, pr;
	logic [LvlW-1:0] lw, lr;

	mfe_ram #(.Width(VtxW), .Depth(NumArc)) u_head (
		.clk, .we(he), .addr(ha), .wdata(hw), .rdata(hr));
	mfe_ram #(.Width(CapW), .Depth(NumArc)) u_res (
		.clk, .we(re), .addr(ra), .wdata(rw), .rdata(rr));
	mfe_ram #(.Width(ArcPW), .Depth(NumArc)) u_next (
		.clk, .we(ne), .addr(na), .wdata(nw), .rdata(nr));
	mfe_ram #(.Width(ArcPW), .Depth(NumVtx)) u_first (
		.clk, .we(fe), .addr(fa), .wdata(fw), .rdata(fr));
	mfe_ram #(.Width(LvlW), .Depth(NumVtx)) u_lvl (
		.clk, .we(le), .addr(la), .wdata(lw), .rdata(lr));
	mfe_ram #(.Width(ArcPW), .Depth(NumVtx)) u_cur (
		.clk, .we(ce), .addr(ca), .wdata(cw), .rdata(cr));
	mfe_ram #(.Width(VtxW), .Depth(NumVtx)) u_queue (
		.clk, .we(qe), .addr(qa), .wdata(qw), .rdata(qr));
	mfe_ram #(.Width(ArcPW), .Depth(NumVtx)) u_stack (
		.clk, .we(pe), .addr(pa), .wdata(pw), .rdata(pr));

	assign clr_busy = !clr_q[VtxW];
	assign s_axis_tready = (state_q == S_IDLE) && !clr_busy;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign tbl_full = (cnt_q + 13'd2) > ArcNil;
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	// The reverse partner of the current arc, and the odd slot of a new pair.
	assign rev_a = {a_q[ArcW-1:1], ~a_q[0]};
	assign pair_a = {a_q[ArcW-1:1], 1'b1};

	// A residual arc to an unreached vertex extends the breadth-first pass.
	assign bfs_take = (rr_q != '0) && (lr == LvlNone) && !qt_q[VtxW];
	// A residual arc to a higher level extends the current path.
	assign dfs_take = (rr_q != '0) && (lr != LvlNone) && (lv_q < lr) && !dep_q[VtxW];

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				if (kind_t'(s_axis_tdata[0]) == K_COMPUTE)
					state_n = (src_q == snk_q) ? S_OUT : S_LVL_CLR;
				else if (tbl_full) state_n = S_OUT;
				else state_n = S_ADD_F;
			end
			S_ADD_F: state_n = S_ADD_RD;
			S_ADD_RD: state_n = S_ADD_R;
			S_ADD_R: state_n = S_OUT;
			S_LVL_CLR: state_n = (i_q == 11'(NumVtx - 1)) ? S_BFS_SEED : S_LVL_CLR;
			S_BFS_SEED: state_n = S_BFS_POP;
			S_BFS_POP: state_n = (qh_q < qt_q) ? S_BFS_V : S_CHK_T;
			S_BFS_V: state_n = S_BFS_VW;
			S_BFS_VW: state_n = S_BFS_ARC;
			S_BFS_ARC: state_n = (a_q == ArcNil) ? S_BFS_POP : S_BFS_ARCW;
			S_BFS_ARCW: state_n = S_BFS_CHK;
			S_BFS_CHK: state_n = S_BFS_ARC;
			S_CHK_T: state_n = S_CHK_TW;
			S_CHK_TW: state_n = (lr == LvlNone) ? S_OUT : S_CUR_RD;
			S_CUR_RD: state_n = S_CUR_WR;
			S_CUR_WR: state_n = (i_q == 11'(NumVtx - 1)) ? S_DFS_T : S_CUR_RD;
			S_DFS_T: state_n = (v_q == snk_q) ? S_AUG_MIN : S_DFS_CW;
			S_DFS_CW: begin
				if (cr != ArcNil) state_n = S_DFS_AW;
				else if (dep_q == '0) state_n = S_LVL_CLR;
				else state_n = S_POP_RD;
			end
			S_DFS_AW: state_n = S_DFS_LVL;
			S_DFS_LVL: state_n = S_DFS_T;
			S_POP_RD: state_n = S_POP_P;
			S_POP_P: state_n = S_POP_H;
			S_POP_H: state_n = S_DFS_T;
			S_AUG_MIN: state_n = (i_q == dep_q) ? S_AUG_UPD : S_AUG_MP;
			S_AUG_MP: state_n = S_AUG_MR;
			S_AUG_MR: state_n = S_AUG_MIN;
			S_AUG_UPD: state_n = (i_q == dep_q) ? S_DFS_T : S_AUG_UP;
			S_AUG_UP: state_n = S_AUG_UF;
			S_AUG_UF: state_n = S_AUG_RR;
			S_AUG_RR: state_n = S_AUG_RF;
			S_AUG_RF: state_n = S_AUG_UPD;
			S_OUT: if (out_load) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		he = 1'b0; re = 1'b0; ne = 1'b0; fe = 1'b0;
		le = 1'b0; ce = 1'b0; qe = 1'b0; pe = 1'b0;
		ha = a_q[ArcW-1:0]; ra = a_q[ArcW-1:0]; na = a_q[ArcW-1:0];
		fa = u_q; la = v_q; ca = v_q; qa = qh_q[VtxW-1:0]; pa = i_q[VtxW-1:0];
		hw = w_q; rw = cap_q; nw = fr; fw = a_q; lw = LvlNone; cw = fr; qw = h_q; pw = a_q;
		if (clr_busy) begin
			fe = 1'b1; fa = clr_q[VtxW-1:0]; fw = ArcNil;
		end else begin
			unique case (state_q)
				S_IDLE: fa = s_axis_tdata[10:1];
				S_ADD_F: begin
					he = 1'b1; re = 1'b1; ne = 1'b1; fe = 1'b1;
					hw = w_q; rw = cap_q; nw = fr; fa = u_q; fw = a_q;
				end
				S_ADD_RD: fa = w_q;
				S_ADD_R: begin
					he = 1'b1; re = 1'b1; ne = 1'b1; fe = 1'b1;
					ha = pair_a; ra = pair_a; na = pair_a;
					hw = u_q; rw = '0; nw = fr; fa = w_q; fw = {a_q[ArcPW-1:1], 1'b1};
				end
				S_LVL_CLR: begin
					le = 1'b1; la = i_q[VtxW-1:0]; lw = LvlNone;
				end
				S_BFS_SEED: begin
					le = 1'b1; la = src_q; lw = '0;
					qe = 1'b1; qa = '0; qw = src_q;
				end
				S_BFS_POP: qa = qh_q[VtxW-1:0];
				S_BFS_V: begin fa = qr; la = qr; end
				S_BFS_VW: ;
				S_BFS_ARC: ;
				S_BFS_ARCW: la = hr;
				S_BFS_CHK: begin
					if (bfs_take) begin
						le = 1'b1; la = h_q; lw = lv_q + 11'd1;
						qe = 1'b1; qa = qt_q[VtxW-1:0]; qw = h_q;
					end
				end
				S_CHK_T: la = snk_q;
				S_CHK_TW: ;
				S_CUR_RD: fa = i_q[VtxW-1:0];
				S_CUR_WR: begin ce = 1'b1; ca = i_q[VtxW-1:0]; cw = fr; end
				S_DFS_T: begin ca = v_q; la = v_q; end
				S_DFS_CW: begin
					ha = cr[ArcW-1:0]; ra = cr[ArcW-1:0]; na = cr[ArcW-1:0];
				end
				S_DFS_AW: la = hr;
				S_DFS_LVL: begin
					if (dfs_take) begin
						pe = 1'b1; pa = dep_q[VtxW-1:0]; pw = a_q;
					end else begin
						ce = 1'b1; ca = v_q; cw = nxt_q;
					end
				end
				S_POP_RD: pa = dep_q[VtxW-1:0] - 10'd1;
				S_POP_P: begin
					ha = {pr[ArcW-1:1], ~pr[0]}; na = pr[ArcW-1:0];
				end
				S_POP_H: begin ce = 1'b1; ca = hr; cw = nr; end
				S_AUG_MIN: pa = i_q[VtxW-1:0];
				S_AUG_MP: ra = pr[ArcW-1:0];
				S_AUG_MR: ;
				S_AUG_UPD: pa = i_q[VtxW-1:0];
				S_AUG_UP: ra = pr[ArcW-1:0];
				S_AUG_UF: begin
					re = 1'b1; ra = a_q[ArcW-1:0]; rw = rr - b_q;
				end
				S_AUG_RR: ra = rev_a;
				S_AUG_RF: begin
					re = 1'b1; ra = rev_a; rw = rr + b_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q <= '0;
			snk_q <= 10'd1;
			cnt_q <= '0;
			clr_q <= '0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CfgSink) snk_q <= cfg_wdata;
				else src_q <= cfg_wdata;
			end
			if (clr_busy) clr_q <= clr_q + 11'd1;
			state_q <= state_n;
			if (state_q == S_ADD_R) cnt_q <= cnt_q + 13'd2;
			if (out_load) begin
				m_valid_q <= 1'b1;
				m_data_q <= {4'd0, flow_q, st_q};
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				u_q <= s_axis_tdata[10:1];
				w_q <= s_axis_tdata[20:11];
				cap_q <= s_axis_tdata[50:21];
				a_q <= cnt_q;
				flow_q <= '0;
				i_q <= '0;
				if (kind_t'(s_axis_tdata[0]) == K_COMPUTE) st_q <= ST_FLOW;
				else if (tbl_full) st_q <= ST_FULL;
				else st_q <= ST_STORED;
			end
			S_LVL_CLR: i_q <= i_q + 11'd1;
			S_BFS_SEED: begin qh_q <= '0; qt_q <= 11'd1; end
			S_BFS_POP: if (qh_q < qt_q) qh_q <= qh_q + 11'd1;
			S_BFS_VW: begin a_q <= fr; lv_q <= lr; end
			S_BFS_ARCW: begin h_q <= hr; rr_q <= rr; nxt_q <= nr; end
			S_BFS_CHK: begin
				if (bfs_take) qt_q <= qt_q + 11'd1;
				a_q <= nxt_q;
			end
			S_CHK_TW: begin i_q <= '0; dep_q <= '0; v_q <= src_q; end
			S_CUR_WR: i_q <= i_q + 11'd1;
			S_DFS_T: begin i_q <= '0; b_q <= PathCap; end
			S_DFS_CW: begin
				a_q <= cr; lv_q <= lr;
				// A finished phase starts the level clear from vertex zero.
				if (cr == ArcNil) i_q <= '0;
			end
			S_DFS_AW: begin h_q <= hr; rr_q <= rr; nxt_q <= nr; end
			S_DFS_LVL: if (dfs_take) begin
				dep_q <= dep_q + 11'd1; v_q <= h_q;
			end
			S_POP_RD: dep_q <= dep_q - 11'd1;
			S_POP_H: v_q <= hr;
			S_AUG_MIN: if (i_q == dep_q) i_q <= '0;
			S_AUG_MR: begin
				if (rr < b_q) b_q <= rr;
				i_q <= i_q + 11'd1;
			end
			S_AUG_UPD: if (i_q == dep_q) begin
				flow_q <= flow_q + {12'd0, b_q};
				dep_q <= '0;
				v_q <= src_q;
			end
			S_AUG_UP: a_q <= pr;
			S_AUG_RF: i_q <= i_q + 11'd1;
			default: ;
		endcase
	end

	// A stalled result stays put until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
	// No item is taken while the first-arc table is being cleared.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_axis_tready);
	// Arcs are stored in pairs and never beyond the table.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] == 1'b0) && (cnt_q <= ArcNil));

endmodule
`default_nettype wire
